// ===== rtl/core/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, sizes and the Paeth predictor for the PNG row unfilter.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int HIST_W = $clog2(MAX_PIXEL_BYTES);
  localparam int BPP_W  = 4;
  localparam int LEN_W  = 14;
  localparam int CFG_W  = 14;

  localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(4);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_ROW_BYTES);
  localparam logic [BPP_W-1:0] BPP_MAX   = BPP_W'(MAX_PIXEL_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_ROW_BYTES);

  typedef enum logic [1:0] {
    OP_SUB   = 2'd0,
    OP_UP    = 2'd1,
    OP_AVG   = 2'd2,
    OP_PAETH = 2'd3
  } op_t;

  typedef enum logic {
    REG_BPP     = 1'b0,
    REG_ROW_LEN = 1'b1
  } reg_idx_t;

  // ties prefer a, then b
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [7:0] pa;
    logic [7:0] pb;
    logic [9:0] sum_ab;
    logic [9:0] two_c;
    logic [9:0] pc;
    pa     = (b >= c) ? (b - c) : (c - b);
    pb     = (a >= c) ? (a - c) : (c - a);
    sum_ab = {2'b00, a} + {2'b00, b};
    two_c  = {1'b0, c, 1'b0};
    pc     = (sum_ab >= two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
    if ((pa <= pb) && ({2'b00, pa} <= pc)) begin
      return a;
    end else if ({2'b00, pb} <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== rtl/core/pru_if.sv =====
// ----------------------------------------------------------------------------
// pru_if
// Valid/ready stream interfaces for filtered input bytes and rebuilt bytes.
// ----------------------------------------------------------------------------
interface pru_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;
  logic [1:0] operation;
  logic       first_row;

  modport source (output valid, output filtered_byte, output operation,
                  output first_row, input ready);
  modport sink   (input valid, input filtered_byte, input operation,
                  input first_row, output ready);
endinterface

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] recon_byte;
  logic       row_end;

  modport source (output valid, output recon_byte, output row_end, input ready);
  modport sink   (input valid, input recon_byte, input row_end, output ready);
endinterface

// ===== rtl/core/pru_ram.sv =====
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/png_row_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_row_unfilter
// Byte-serial PNG scanline filter reconstruction (sub, up, average, Paeth).
// ----------------------------------------------------------------------------
// Takes one filtered byte per clock and returns one rebuilt byte per clock
// while the output is not stalled, with row_end on the last byte of each
// scanline. The previous row sits in a single-port-read line RAM; a byte's
// above neighbor is read in the transfer cycle, and in the following cycle
// the byte is rebuilt, written back to the line RAM and written into the
// output queue. Left and above-left neighbors come from two short shift
// histories. Throughput is one byte per cycle without output stalls, bounded
// by the line RAM's one read and one write per cycle; a four-entry output
// queue absorbs output stalls. Write bytes_per_pixel and row_length only
// while no bytes are in flight.
module png_row_unfilter (
  input  logic                       clk,
  input  logic                       rst_n,
  pru_in_if.sink                     in_if,
  pru_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pru_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // configuration
  logic [pru_pkg::BPP_W-1:0] bpp_r;
  logic [pru_pkg::LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= pru_pkg::BPP_RESET;
      len_r <= pru_pkg::LEN_RESET;
    end else if (cfg_we) begin
      unique case (pru_pkg::reg_idx_t'(cfg_index))
        pru_pkg::REG_BPP:     bpp_r <= cfg_wdata[pru_pkg::BPP_W-1:0];
        pru_pkg::REG_ROW_LEN: len_r <= cfg_wdata[pru_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [pru_pkg::BPP_W-1:0] bpp_eff;
  logic [pru_pkg::LEN_W-1:0] len_eff;

  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = pru_pkg::BPP_W'(1);
    end else if (bpp_r > pru_pkg::BPP_MAX) begin
      bpp_eff = pru_pkg::BPP_MAX;
    end else begin
      bpp_eff = bpp_r;
    end
    if (len_r == '0) begin
      len_eff = pru_pkg::LEN_W'(1);
    end else if (len_r > pru_pkg::LEN_MAX) begin
      len_eff = pru_pkg::LEN_MAX;
    end else begin
      len_eff = len_r;
    end
  end

  // stage 0: transfer, column tracking, line RAM read
  logic                      in_xfer;
  logic [pru_pkg::COL_W-1:0] column_r;
  logic [pru_pkg::COL_W-1:0] column_nxt;
  logic                      last;
  logic [pru_pkg::LEN_W-1:0] col_plus1;

  logic                      s1_valid_r;
  logic [7:0]                s1_byte_r;
  pru_pkg::op_t              s1_op_r;
  logic                      s1_top_r;
  logic [pru_pkg::COL_W-1:0] s1_col_r;
  logic                      s1_last_r;
  logic                      s1_fwd_r;
  logic [7:0]                s1_fwd_byte_r;

  logic [QCNT_W-1:0]         q_cnt_r;
  logic [7:0]                recon;

  // queue plus the byte in flight never exceed the queue depth
  assign in_if.ready = ({1'b0, q_cnt_r} + {{QCNT_W{1'b0}}, s1_valid_r})
                       < (QCNT_W + 1)'(QDEPTH);
  assign in_xfer     = in_if.valid && in_if.ready;

  assign col_plus1   = {{(pru_pkg::LEN_W-pru_pkg::COL_W){1'b0}}, column_r}
                       + pru_pkg::LEN_W'(1);
  assign last        = (col_plus1 >= len_eff);
  assign column_nxt  = last ? '0 : col_plus1[pru_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      if (in_xfer) begin
        column_r <= column_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r     <= in_if.filtered_byte;
      s1_op_r       <= pru_pkg::op_t'(in_if.operation);
      s1_top_r      <= in_if.first_row;
      s1_col_r      <= column_r;
      s1_last_r     <= last;
      // the byte in stage 1 writes this entry at the same edge as the read
      s1_fwd_r      <= s1_valid_r && (s1_col_r == column_r);
      s1_fwd_byte_r <= recon;
    end
  end

  logic [7:0] ram_rdata;

  pru_ram #(
    .WIDTH (8),
    .DEPTH (pru_pkg::MAX_ROW_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (recon),
    .re    (in_xfer),
    .raddr (column_r),
    .rdata (ram_rdata)
  );

  // stage 1: predict, rebuild, write back
  logic [7:0]                 left_hist_r  [pru_pkg::MAX_PIXEL_BYTES];
  logic [7:0]                 uleft_hist_r [pru_pkg::MAX_PIXEL_BYTES];
  logic [pru_pkg::HIST_W-1:0] hist_sel;
  logic                       has_left;
  logic [7:0]                 nb_a;
  logic [7:0]                 nb_b;
  logic [7:0]                 nb_c;
  logic [8:0]                 avg_sum;
  logic [7:0]                 pred;

  assign hist_sel = pru_pkg::HIST_W'(bpp_eff - pru_pkg::BPP_W'(1));
  assign has_left = (s1_col_r >= {{(pru_pkg::COL_W-pru_pkg::BPP_W){1'b0}}, bpp_eff});

  always_comb begin
    nb_b    = s1_top_r ? 8'd0 : (s1_fwd_r ? s1_fwd_byte_r : ram_rdata);
    nb_a    = has_left ? left_hist_r[hist_sel] : 8'd0;
    nb_c    = (has_left && !s1_top_r) ? uleft_hist_r[hist_sel] : 8'd0;
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (s1_op_r)
      pru_pkg::OP_SUB:   pred = nb_a;
      pru_pkg::OP_UP:    pred = nb_b;
      pru_pkg::OP_AVG:   pred = avg_sum[8:1];
      pru_pkg::OP_PAETH: pred = pru_pkg::paeth(nb_a, nb_b, nb_c);
      default:           pred = nb_a;
    endcase
    recon = s1_byte_r + pred;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      left_hist_r[0]  <= recon;
      uleft_hist_r[0] <= nb_b;
      for (int i = 1; i < pru_pkg::MAX_PIXEL_BYTES; i++) begin
        left_hist_r[i]  <= left_hist_r[i-1];
        uleft_hist_r[i] <= uleft_hist_r[i-1];
      end
    end
  end

  // output queue
  logic [8:0]        q_data_r [QDEPTH];
  logic [QPTR_W-1:0] q_wr_ptr_r;
  logic [QPTR_W-1:0] q_rd_ptr_r;
  logic              out_xfer;

  assign out_xfer          = out_if.valid && out_if.ready;
  assign out_if.valid      = (q_cnt_r != '0);
  assign out_if.recon_byte = q_data_r[q_rd_ptr_r][8:1];
  assign out_if.row_end    = q_data_r[q_rd_ptr_r][0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= '0;
      q_rd_ptr_r <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (s1_valid_r) begin
        q_wr_ptr_r <= q_wr_ptr_r + QPTR_W'(1);
      end
      if (out_xfer) begin
        q_rd_ptr_r <= q_rd_ptr_r + QPTR_W'(1);
      end
      if (s1_valid_r && !out_xfer) begin
        q_cnt_r <= q_cnt_r + QCNT_W'(1);
      end else if (!s1_valid_r && out_xfer) begin
        q_cnt_r <= q_cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      q_data_r[q_wr_ptr_r] <= {recon, s1_last_r};
    end
  end

  // checks
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_cnt_r != QCNT_W'(QDEPTH)))
    else $error("output queue full while a byte leaves stage 1");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("transferred byte did not reach stage 1");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && last) |=> (column_r == '0))
    else $error("column did not wrap at row end");

endmodule
